FILE: hdl/rlbao_pkg.sv
// Shared types and constants for the relay light controller.
// No dependencies; imported by every rlbao_* module and the top level.
package rlbao_pkg;

    localparam int PATTERN_SLOTS = 10;
    localparam int SLOT_W        = $clog2(PATTERN_SLOTS);
    localparam int CNT_W         = $clog2(PATTERN_SLOTS + 1);

    localparam int MS_PER_SECOND   = 1000;
    localparam int DEFAULT_SLOT_MS = 500;
    localparam int MIN_SLOT_MS     = 200;
    localparam int MS_PER_TENTH    = 100;
    localparam int MAX_TENTHS      = 655;
    localparam int MAX_MIN_LEVEL   = 20;
    localparam int MAX_LEVEL       = 100;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_ON     = 3'd1;
    localparam logic [2:0] OP_OFF    = 3'd2;
    localparam logic [2:0] OP_TOGGLE = 3'd3;
    localparam logic [2:0] OP_WRITE  = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;
    localparam logic [2:0] OP_BLINK  = 3'd6;

    localparam logic [1:0] REG_MIN_BRIGHTNESS = 2'd0;
    localparam logic [1:0] REG_MAX_BRIGHTNESS = 2'd1;
    localparam logic [1:0] REG_AUTO_OFF       = 2'd2;
    localparam logic [1:0] REG_BLINK_SECONDS  = 2'd3;

    typedef struct packed {
        logic [4:0]  min_brightness;
        logic [6:0]  max_brightness;
        logic [19:0] auto_off_ms;
        logic [25:0] blink_ms;
    } cfg_t;

    typedef struct packed {
        logic       write;
        logic       clear;
        logic       start;
        logic [3:0] slot_index;
        logic [9:0] slot_tenths;
    } pat_cmd_t;

    typedef struct packed {
        logic [15:0]       cur_ms;
        logic [SLOT_W-1:0] next_slot;
        logic              next_found;
    } pat_stat_t;

endpackage

FILE: hdl/rlbao_cfg.sv
// Configuration registers with write-side saturation; timer limits kept in ms.
// Depends on rlbao_pkg.
module rlbao_cfg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data,
    output rlbao_pkg::cfg_t  cfg
);
    import rlbao_pkg::*;

    logic [4:0]  min_reg;
    logic [6:0]  max_reg;
    logic [19:0] auto_ms_reg;
    logic [25:0] blink_ms_reg;
    logic [4:0]  min_next;
    logic [6:0]  max_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        min_next = (cfg_data[4:0] > 5'(MAX_MIN_LEVEL)) ? 5'(MAX_MIN_LEVEL) : cfg_data[4:0];
        max_next = (cfg_data[6:0] < {2'b00, min_reg}) ? {2'b00, min_reg} : cfg_data[6:0];
        if (max_next > 7'(MAX_LEVEL))
        begin
            max_next = 7'(MAX_LEVEL);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg      <= '0;
            max_reg      <= 7'(MAX_LEVEL);
            auto_ms_reg  <= '0;
            blink_ms_reg <= 26'(5 * MS_PER_SECOND);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MIN_BRIGHTNESS: min_reg <= min_next;
                REG_MAX_BRIGHTNESS: max_reg <= max_next;
                REG_AUTO_OFF:
                    auto_ms_reg <= 20'(cfg_data[9:0]) * 20'(MS_PER_SECOND);
                REG_BLINK_SECONDS:
                    blink_ms_reg <= 26'(cfg_data) * 26'(MS_PER_SECOND);
                default: ;
            endcase
        end
    end

    assign cfg.min_brightness = min_reg;
    assign cfg.max_brightness = max_reg;
    assign cfg.auto_off_ms    = auto_ms_reg;
    assign cfg.blink_ms       = blink_ms_reg;

endmodule

FILE: hdl/rlbao_pattern.sv
// Blink pattern slots, written-slot count and next non-empty slot search.
// Depends on rlbao_pkg.
module rlbao_pattern
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  rlbao_pkg::pat_cmd_t                cmd,
    input  logic [rlbao_pkg::SLOT_W-1:0]       phase_slot,
    output rlbao_pkg::pat_stat_t               stat
);
    import rlbao_pkg::*;

    logic [15:0]      store_reg [PATTERN_SLOTS];
    logic [CNT_W-1:0] count_reg;
    logic [9:0]       tenths_sat;
    logic [16:0]      prod;
    logic [15:0]      slot_ms;
    logic             idx_ok;
    logic [SLOT_W-1:0] pos;
    logic [SLOT_W-1:0] nxt;
    logic             found;

    always_comb
    begin
        tenths_sat = (cmd.slot_tenths > 10'(MAX_TENTHS)) ? 10'(MAX_TENTHS) : cmd.slot_tenths;
        prod       = 17'(tenths_sat) * 17'(MS_PER_TENTH);
        slot_ms    = (prod < 17'(MIN_SLOT_MS)) ? 16'(MIN_SLOT_MS) : prod[15:0];
        idx_ok     = {1'b0, cmd.slot_index} < 5'(PATTERN_SLOTS);
    end

    // cyclic search starting after the current slot, ending on it
    always_comb
    begin
        found = 1'b0;
        nxt   = phase_slot;
        pos   = phase_slot;
        for (int k = 0; k < PATTERN_SLOTS; k++)
        begin
            pos = (pos == SLOT_W'(PATTERN_SLOTS - 1)) ? '0 : pos + 1'b1;
            if (!found && store_reg[pos] != '0)
            begin
                found = 1'b1;
                nxt   = pos;
            end
        end
    end

    assign stat.cur_ms     = store_reg[phase_slot];
    assign stat.next_slot  = nxt;
    assign stat.next_found = found;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PATTERN_SLOTS; i++)
            begin
                store_reg[i] <= (i < 2) ? 16'(DEFAULT_SLOT_MS) : '0;
            end
            count_reg <= CNT_W'(2);
        end
        else if (cmd.write)
        begin
            if (idx_ok)
            begin
                store_reg[cmd.slot_index[SLOT_W-1:0]] <= slot_ms;
                if (count_reg < CNT_W'(PATTERN_SLOTS))
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
        else if (cmd.clear)
        begin
            for (int i = 0; i < PATTERN_SLOTS; i++)
            begin
                store_reg[i] <= '0;
            end
            count_reg <= '0;
        end
        else if (cmd.start && count_reg < CNT_W'(2))
        begin
            for (int i = 0; i < PATTERN_SLOTS; i++)
            begin
                store_reg[i] <= (i < 2) ? 16'(DEFAULT_SLOT_MS) : '0;
            end
            count_reg <= CNT_W'(2);
        end
    end

endmodule

FILE: hdl/relay_light_blink_autooff.sv
// Top level of the relay light controller: state update and output buffer.
// Depends on rlbao_pkg, rlbao_cfg and rlbao_pattern.
//
// Usage:
//   s_* carries one command word per beat: a 1 ms tick, on, off, toggle,
//   pattern slot write, pattern clear or blink start. Every accepted word
//   returns exactly one status word on m_*: relay drive, brightness, light
//   state and blink state, all taken after the command has been applied.
//   cfg_* writes the four settings (index 0..3); it is always ready. The user
//   must write it only while no command is in flight; the block leaves this
//   unenforced. Each status word is registered before it appears on m_*.
//   Throughput: one word per cycle while s_tready is high.
//   Stall: a result register plus one skid word; s_tready drops only when
//   both hold words the receiver has not taken, and rises again the cycle
//   after the receiver takes one.
//   Reset: relay open, brightness 0, timers stopped, pattern 500/500 ms,
//   settings min 0, max 100, auto-off disabled, blink time 5 s.
module relay_light_blink_autooff
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // operation[2:0], no_auto_off[3], slot_index[7:4],
                                   // slot_tenths[17:8], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // relay_on[0], brightness_pct[7:1], light_is_on[8],
                                   // blink_active[9], zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import rlbao_pkg::*;

    cfg_t      cfg;
    pat_cmd_t  pcmd;
    pat_stat_t pstat;

    logic [2:0] operation;
    logic       no_auto_off;
    logic       accept;

    logic [6:0]        level_reg,       level_next;
    logic              relay_reg,       relay_next;
    logic              on_run_reg,      on_run_next;
    logic [19:0]       on_ms_reg,       on_ms_next;
    logic              blinking_reg,    blinking_next;
    logic [25:0]       blink_ms_reg,    blink_ms_next;
    logic              lit_reg,         lit_next;
    logic [SLOT_W-1:0] slot_reg,        slot_next;
    logic [15:0]       phase_ms_reg,    phase_ms_next;

    logic signed [8:0] below;
    logic signed [8:0] above;
    logic [15:0]       phase_inc;
    logic              lit_update;
    logic              lit_val;
    logic [15:0]       result;

    logic        main_valid_reg;
    logic [15:0] main_data_reg;
    logic        skid_valid_reg;
    logic [15:0] skid_data_reg;

    assign operation   = s_tdata[2:0];
    assign no_auto_off = s_tdata[3];
    assign s_tready    = !skid_valid_reg;
    assign accept      = s_tvalid && s_tready;

    rlbao_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign pcmd.write       = accept && operation == OP_WRITE;
    assign pcmd.clear       = accept && operation == OP_CLEAR;
    assign pcmd.start       = accept && operation == OP_BLINK;
    assign pcmd.slot_index  = s_tdata[7:4];
    assign pcmd.slot_tenths = s_tdata[17:8];

    rlbao_pattern u_pattern
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (pcmd),
        .phase_slot (slot_reg),
        .stat       (pstat)
    );

    always_comb
    begin
        level_next    = level_reg;
        relay_next    = relay_reg;
        on_run_next   = on_run_reg;
        on_ms_next    = on_ms_reg;
        blinking_next = blinking_reg;
        blink_ms_next = blink_ms_reg;
        lit_next      = lit_reg;
        slot_next     = slot_reg;
        phase_ms_next = phase_ms_reg;
        below         = 9'(level_reg) - 9'(cfg.min_brightness);
        above         = 9'(cfg.max_brightness) - 9'(level_reg);
        phase_inc     = phase_ms_reg + 1'b1;
        lit_update    = 1'b0;
        lit_val       = 1'b0;

        unique case (operation)
            OP_TICK:
            begin
                if (blinking_reg)
                begin
                    if (blink_ms_reg != '1)
                    begin
                        blink_ms_next = blink_ms_reg + 1'b1;
                    end
                    if (blink_ms_next > cfg.blink_ms)
                    begin
                        relay_next    = !(below < above);
                        blinking_next = 1'b0;
                    end
                    else
                    begin
                        if (phase_inc > pstat.cur_ms)
                        begin
                            if (pstat.next_found)
                            begin
                                slot_next     = pstat.next_slot;
                                phase_ms_next = 16'd1;
                                lit_update    = 1'b1;
                            end
                            else
                            begin
                                phase_ms_next = '0;
                            end
                        end
                        else
                        begin
                            phase_ms_next = phase_inc;
                            lit_update    = 1'b1;
                        end
                        lit_val = !slot_next[0];
                        if (lit_update && lit_val != lit_reg)
                        begin
                            lit_next   = lit_val;
                            relay_next = lit_val;
                        end
                    end
                end
                if (on_run_reg)
                begin
                    if (on_ms_reg != '1)
                    begin
                        on_ms_next = on_ms_reg + 1'b1;
                    end
                    if (cfg.auto_off_ms != '0 && on_ms_next > cfg.auto_off_ms)
                    begin
                        on_run_next = 1'b0;
                        on_ms_next  = '0;
                        relay_next  = 1'b0;
                        level_next  = 7'(cfg.min_brightness);
                    end
                end
            end
            OP_ON:
            begin
                on_run_next = !no_auto_off;
                on_ms_next  = '0;
                relay_next  = 1'b1;
                level_next  = cfg.max_brightness;
            end
            OP_OFF:
            begin
                on_run_next = 1'b0;
                on_ms_next  = '0;
                relay_next  = 1'b0;
                level_next  = 7'(cfg.min_brightness);
            end
            OP_TOGGLE:
            begin
                on_ms_next = '0;
                if (level_reg == 7'(cfg.min_brightness))
                begin
                    on_run_next = !no_auto_off;
                    relay_next  = 1'b1;
                    level_next  = cfg.max_brightness;
                end
                else
                begin
                    on_run_next = 1'b0;
                    relay_next  = 1'b0;
                    level_next  = 7'(cfg.min_brightness);
                end
            end
            OP_BLINK:
            begin
                lit_next      = 1'b0;
                blink_ms_next = '0;
                slot_next     = '0;
                phase_ms_next = '0;
                blinking_next = 1'b1;
            end
            default: ;
        endcase

        result = {6'b0, blinking_next, level_next != 7'(cfg.min_brightness),
                  level_next, relay_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg    <= '0;
            relay_reg    <= 1'b0;
            on_run_reg   <= 1'b0;
            on_ms_reg    <= '0;
            blinking_reg <= 1'b0;
            blink_ms_reg <= '0;
            lit_reg      <= 1'b0;
            slot_reg     <= '0;
            phase_ms_reg <= '0;
        end
        else if (accept)
        begin
            level_reg    <= level_next;
            relay_reg    <= relay_next;
            on_run_reg   <= on_run_next;
            on_ms_reg    <= on_ms_next;
            blinking_reg <= blinking_next;
            blink_ms_reg <= blink_ms_next;
            lit_reg      <= lit_next;
            slot_reg     <= slot_next;
            phase_ms_reg <= phase_ms_next;
        end
    end

    // result register plus skid word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || m_tready)
        begin
            main_data_reg <= skid_valid_reg ? skid_data_reg : result;
        end
        else if (accept)
        begin
            skid_data_reg <= result;
        end
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = main_data_reg;

endmodule

FILE: verif/relay_light_blink_autooff_test.sv
// Self-checking bench for relay_light_blink_autooff: streams commands, checks each status
// word against an in-bench prediction of the controller, and steps through several settings.
// Depends on rlbao_pkg and the relay_light_blink_autooff RTL.
`timescale 1ns / 1ps

module relay_light_blink_autooff_test;

    import rlbao_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASE_ITEMS  = 100;
    localparam int DRAIN_CYCLES = 4;

    typedef struct packed {
        logic [9:0] slot_tenths;
        logic [3:0] slot_index;
        logic       no_auto_off;
        logic [2:0] operation;
    } cmd_word_t;

    typedef struct packed {
        logic       blink_active;
        logic       light_is_on;
        logic [6:0] brightness_pct;
        logic       relay_on;
    } status_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // predicted settings
    logic [4:0]  min_pct;
    logic [6:0]  max_pct;
    logic [9:0]  auto_off_s;
    logic [15:0] blink_s;

    // predicted controller state
    logic [6:0]  lamp_level;
    logic        lamp_relay;
    logic        auto_running;
    logic [19:0] auto_ms;
    logic        blink_on;
    logic [25:0] blink_ms;
    logic        blink_lit_q;
    logic [15:0] slot_ms [PATTERN_SLOTS];
    logic [3:0]  slots_written;
    logic [3:0]  cur_slot;
    logic [15:0] cur_slot_ms;

    cmd_word_t cmd_backlog [$];
    status_t   pending_status [$];

    int      burst_left = 5;
    int      gap_left = 0;
    int      rcv_cycle = 0;
    int      cycle_count = 0;
    int      mismatch_count = 0;
    int      phase_items = 0;
    status_t seen_status;
    status_t want_status;

    relay_light_blink_autooff DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void load_default_slots();
        foreach (slot_ms[i])
            slot_ms[i] = '0;
        slot_ms[0] = DEFAULT_SLOT_MS;
        slot_ms[1] = DEFAULT_SLOT_MS;
        slots_written = 4'd2;
    endfunction

    function automatic void lamp_on(input logic no_auto);
        auto_running = !no_auto;
        auto_ms = '0;
        lamp_relay = 1'b1;
        lamp_level = max_pct;
    endfunction

    function automatic void lamp_off();
        auto_running = 1'b0;
        auto_ms = '0;
        lamp_relay = 1'b0;
        lamp_level = {2'b00, min_pct};
    endfunction

    function automatic status_t next_status(input cmd_word_t c);
        status_t r;
        int      ms;
        int      below;
        int      above;
        int      s;
        logic    found;
        logic    lit;
        case (c.operation)
            OP_TICK:
            begin
                if (blink_on)
                begin
                    if (blink_ms != '1)
                        blink_ms++;
                    if (int'(blink_ms) > int'(blink_s) * MS_PER_SECOND)
                    begin
                        below = int'(lamp_level) - int'(min_pct);
                        above = int'(max_pct) - int'(lamp_level);
                        lamp_relay = (below < above) ? 1'b0 : 1'b1;
                        blink_on = 1'b0;
                    end
                    else
                    begin
                        cur_slot_ms++;
                        found = 1'b1;
                        if (cur_slot_ms > slot_ms[cur_slot])
                        begin
                            found = 1'b0;
                            s = cur_slot;
                            for (int k = 0; k < PATTERN_SLOTS; k++)
                            begin
                                if (!found)
                                begin
                                    s = (s + 1) % PATTERN_SLOTS;
                                    if (slot_ms[s] != 0)
                                        found = 1'b1;
                                end
                            end
                            if (found)
                            begin
                                cur_slot = s[3:0];
                                cur_slot_ms = 16'd1;
                            end
                            else
                                cur_slot_ms = '0;
                        end
                        // empty pattern: phase returns to zero, lit flag and relay hold
                        if (found)
                        begin
                            lit = ~cur_slot[0];
                            if (lit != blink_lit_q)
                            begin
                                blink_lit_q = lit;
                                lamp_relay = lit;
                            end
                        end
                    end
                end
                if (auto_running)
                begin
                    if (auto_ms != '1)
                        auto_ms++;
                    if (auto_off_s != 0 && int'(auto_ms) > int'(auto_off_s) * MS_PER_SECOND)
                        lamp_off();
                end
            end
            OP_ON:
                lamp_on(c.no_auto_off);
            OP_OFF:
                lamp_off();
            OP_TOGGLE:
            begin
                if (lamp_level == {2'b00, min_pct})
                    lamp_on(c.no_auto_off);
                else
                    lamp_off();
            end
            OP_WRITE:
            begin
                if (c.slot_index < PATTERN_SLOTS)
                begin
                    ms = (c.slot_tenths > MAX_TENTHS) ? MAX_TENTHS : int'(c.slot_tenths);
                    ms = ms * MS_PER_TENTH;
                    if (ms < MIN_SLOT_MS)
                        ms = MIN_SLOT_MS;
                    slot_ms[c.slot_index] = ms[15:0];
                    if (slots_written < PATTERN_SLOTS)
                        slots_written++;
                end
            end
            OP_CLEAR:
            begin
                foreach (slot_ms[i])
                    slot_ms[i] = '0;
                slots_written = '0;
            end
            OP_BLINK:
            begin
                if (slots_written < 2)
                    load_default_slots();
                blink_lit_q = 1'b0;
                blink_ms = '0;
                cur_slot = '0;
                cur_slot_ms = '0;
                blink_on = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.relay_on = lamp_relay;
        r.brightness_pct = lamp_level;
        r.light_is_on = (lamp_level != {2'b00, min_pct});
        r.blink_active = blink_on;
        return r;
    endfunction

    function automatic void queue_cmd(input logic [2:0] op, input logic na,
                                      input logic [3:0] idx, input logic [9:0] tenths);
        cmd_word_t c;
        c.operation = op;
        c.no_auto_off = na;
        c.slot_index = idx;
        c.slot_tenths = tenths;
        cmd_backlog.push_back(c);
        phase_items++;
    endfunction

    // tick run, now and then broken by a light command
    function automatic void queue_ticks();
        int n;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 260) : $urandom_range(1, 40);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 149) == 0)
                queue_cmd(3'($urandom_range(OP_ON, OP_TOGGLE)), 1'($urandom_range(0, 1)),
                          4'($urandom_range(0, 15)), 10'($urandom_range(0, 1023)));
            else
                queue_cmd(OP_TICK, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                          10'($urandom_range(0, 1023)));
        end
    endfunction

    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || s_tvalid || pending_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        logic [6:0] m;
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MIN_BRIGHTNESS:
                min_pct = (val[4:0] > MAX_MIN_LEVEL) ? 5'(MAX_MIN_LEVEL) : val[4:0];
            REG_MAX_BRIGHTNESS:
            begin
                m = val[6:0];
                if (m < {2'b00, min_pct})
                    m = {2'b00, min_pct};
                if (m > MAX_LEVEL)
                    m = 7'(MAX_LEVEL);
                max_pct = m;
            end
            REG_AUTO_OFF:
                auto_off_s = val[9:0];
            default:
                blink_s = val;
        endcase
    endtask

    // sender: bursts of random length with random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                pending_status.push_back(next_status(cmd_word_t'(s_tdata[17:0])));
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    s_tdata <= {6'b000000, cmd_backlog.pop_front()};
                    s_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(1, 24);
                        gap_left = $urandom_range(1, 8);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: checks each status word, stalls in a rotating pattern
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                seen_status = status_t'(m_tdata[9:0]);
                if (pending_status.size() == 0)
                begin
                    $error("status word with none expected: %h", m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want_status = pending_status.pop_front();
                    if (seen_status.relay_on !== want_status.relay_on)
                    begin
                        $error("relay_on: expected %0d, got %0d",
                               want_status.relay_on, seen_status.relay_on);
                        mismatch_count++;
                    end
                    if (seen_status.brightness_pct !== want_status.brightness_pct)
                    begin
                        $error("brightness_pct: expected %0d, got %0d",
                               want_status.brightness_pct, seen_status.brightness_pct);
                        mismatch_count++;
                    end
                    if (seen_status.light_is_on !== want_status.light_is_on)
                    begin
                        $error("light_is_on: expected %0d, got %0d",
                               want_status.light_is_on, seen_status.light_is_on);
                        mismatch_count++;
                    end
                    if (seen_status.blink_active !== want_status.blink_active)
                    begin
                        $error("blink_active: expected %0d, got %0d",
                               want_status.blink_active, seen_status.blink_active);
                        mismatch_count++;
                    end
                end
            end
            rcv_cycle++;
            case ((rcv_cycle / 512) % 4)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= ((rcv_cycle % 7) < 3);
                default: m_tready <= ((rcv_cycle % 40) >= 30);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int pick;
        int n;
        min_pct = '0;
        max_pct = 7'd100;
        auto_off_s = '0;
        blink_s = 16'd5;
        lamp_level = '0;
        lamp_relay = 1'b0;
        auto_running = 1'b0;
        auto_ms = '0;
        blink_on = 1'b0;
        blink_ms = '0;
        blink_lit_q = 1'b0;
        load_default_slots();
        cur_slot = '0;
        cur_slot_ms = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset settings
        queue_cmd(3'd7, 1'b1, 4'd15, 10'd1023);
        queue_cmd(OP_TICK, 1'b0, 4'd0, 10'd0);
        queue_cmd(OP_TOGGLE, 1'b0, 4'd0, 10'd0);
        queue_cmd(OP_TOGGLE, 1'b1, 4'd0, 10'd0);
        queue_cmd(OP_ON, 1'b1, 4'd0, 10'd0);
        queue_cmd(OP_OFF, 1'b0, 4'd0, 10'd0);
        queue_cmd(OP_ON, 1'b0, 4'd0, 10'd0);
        queue_cmd(OP_WRITE, 1'b0, 4'd15, 10'd5);
        queue_cmd(OP_WRITE, 1'b0, 4'd9, 10'd1023);
        queue_cmd(OP_WRITE, 1'b0, 4'd0, 10'd0);
        queue_cmd(OP_WRITE, 1'b0, 4'd1, 10'd1);
        queue_cmd(OP_WRITE, 1'b0, 4'd2, 10'd3);
        queue_cmd(OP_CLEAR, 1'b0, 4'd0, 10'd0);
        queue_cmd(OP_BLINK, 1'b0, 4'd0, 10'd0);
        queue_cmd(OP_TICK, 1'b0, 4'd0, 10'd0);
        queue_cmd(OP_TICK, 1'b0, 4'd0, 10'd0);
        queue_cmd(OP_CLEAR, 1'b0, 4'd0, 10'd0);
        queue_cmd(OP_TICK, 1'b0, 4'd0, 10'd0);
        queue_cmd(OP_TICK, 1'b0, 4'd0, 10'd0);
        queue_cmd(OP_WRITE, 1'b0, 4'd1, 10'd2);
        queue_cmd(OP_BLINK, 1'b0, 4'd0, 10'd0);
        queue_cmd(OP_TICK, 1'b0, 4'd0, 10'd0);
        queue_cmd(OP_OFF, 1'b0, 4'd0, 10'd0);
        queue_cmd(OP_BLINK, 1'b0, 4'd0, 10'd0);
        queue_cmd(OP_TICK, 1'b0, 4'd0, 10'd0);
        wait_drained();

        for (int ph = 1; ph <= 5; ph++)
        begin
            case (ph)
                1:
                begin
                    write_reg(REG_MIN_BRIGHTNESS, 16'd31);
                    write_reg(REG_MAX_BRIGHTNESS, 16'd127);
                    write_reg(REG_AUTO_OFF, 16'd1);
                    write_reg(REG_BLINK_SECONDS, 16'd0);
                end
                2:
                begin
                    write_reg(REG_MIN_BRIGHTNESS, 16'hFFEA);
                    write_reg(REG_MAX_BRIGHTNESS, 16'd5);
                    write_reg(REG_AUTO_OFF, 16'd0);
                    write_reg(REG_BLINK_SECONDS, 16'd1);
                end
                3:
                begin
                    write_reg(REG_MIN_BRIGHTNESS, 16'd0);
                    write_reg(REG_MAX_BRIGHTNESS, 16'd0);
                    write_reg(REG_AUTO_OFF, 16'd1023);
                    write_reg(REG_BLINK_SECONDS, 16'hFFFF);
                end
                4:
                begin
                    write_reg(REG_MIN_BRIGHTNESS, 16'd20);
                    write_reg(REG_MAX_BRIGHTNESS, 16'd100);
                    write_reg(REG_AUTO_OFF, 16'd1);
                    write_reg(REG_BLINK_SECONDS, 16'd1);
                end
                default:
                begin
                    // max first, so min may end up above it
                    write_reg(REG_MAX_BRIGHTNESS, 16'($urandom_range(0, 100)));
                    write_reg(REG_MIN_BRIGHTNESS, 16'($urandom_range(0, 20)));
                    write_reg(REG_AUTO_OFF, 16'd1);
                    write_reg(REG_BLINK_SECONDS, 16'($urandom_range(0, 2)));
                end
            endcase

            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 9);
                if (pick <= 3)
                begin
                    if ($urandom_range(0, 1) == 0)
                        queue_cmd(OP_CLEAR, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                                  10'($urandom_range(0, 1023)));
                    n = $urandom_range(0, 4);
                    for (int i = 0; i < n; i++)
                        queue_cmd(OP_WRITE, 1'($urandom_range(0, 1)),
                                  4'($urandom_range(0, PATTERN_SLOTS - 1)),
                                  ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 1023))
                                                              : 10'($urandom_range(0, 4)));
                    queue_cmd(OP_BLINK, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                              10'($urandom_range(0, 1023)));
                    queue_ticks();
                end
                else if (pick <= 5)
                begin
                    queue_cmd(($urandom_range(0, 1) == 0) ? OP_ON : OP_TOGGLE,
                              ($urandom_range(0, 3) == 0), 4'($urandom_range(0, 15)),
                              10'($urandom_range(0, 1023)));
                    queue_ticks();
                end
                else if (pick == 6)
                begin
                    n = $urandom_range(1, 4);
                    for (int i = 0; i < n; i++)
                        queue_cmd(3'($urandom_range(OP_ON, OP_TOGGLE)), 1'($urandom_range(0, 1)),
                                  4'($urandom_range(0, 15)), 10'($urandom_range(0, 1023)));
                end
                else if (pick == 7)
                begin
                    n = $urandom_range(1, 5);
                    for (int i = 0; i < n; i++)
                        queue_cmd(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                                  4'($urandom_range(0, 15)), 10'($urandom_range(0, 1023)));
                end
                else if (pick == 8)
                begin
                    // broken setup: a stray index, at most one slot, then start
                    queue_cmd(OP_CLEAR, 1'b0, 4'd0, 10'd0);
                    queue_cmd(OP_WRITE, 1'b0, 4'($urandom_range(PATTERN_SLOTS, 15)),
                              10'($urandom_range(0, 1023)));
                    if ($urandom_range(0, 1) == 0)
                        queue_cmd(OP_WRITE, 1'b0, 4'($urandom_range(0, PATTERN_SLOTS - 1)),
                                  10'($urandom_range(0, 6)));
                    queue_cmd(OP_BLINK, 1'b0, 4'd0, 10'd0);
                    queue_ticks();
                end
                else
                begin
                    wait_drained();
                    queue_ticks();
                end
            end
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: relay_light_blink_autooff.f
hdl/rlbao_pkg.sv
hdl/rlbao_cfg.sv
hdl/rlbao_pattern.sv
hdl/relay_light_blink_autooff.sv
verif/relay_light_blink_autooff_test.sv
